[src/dac_command_parser_defines.svh]
// assertion helpers for the dac command parser checker
`ifndef DAC_COMMAND_PARSER_DEFINES_SVH
`define DAC_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dcp_pkg.sv]
`default_nettype none

package dcp_pkg;

    localparam int DAC_BITS = 12;
    // accumulator times ten plus one digit always fits in four more bits
    localparam int ACC_W    = DAC_BITS + 4;
    localparam int STATUS_W = 3;

    typedef logic [DAC_BITS-1:0] t_dac_word;

    localparam t_dac_word VAL_MAX = {DAC_BITS{1'b1}};
    localparam t_dac_word VAL_MID = {1'b1, {(DAC_BITS-1){1'b0}}};

    // queue depth must be a power of two, pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NOT_DAC,
        ST_BAD_SEP,
        ST_NO_FIRST,
        ST_NO_SECOND
    } t_status;

    typedef enum logic [3:0] {
        PH_D,
        PH_A,
        PH_C,
        PH_SEP,
        PH_SKIP1,
        PH_SIGN1,
        PH_DIG1,
        PH_SKIP2,
        PH_SIGN2,
        PH_DIG2,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        CL_NUL,
        CL_D,
        CL_A,
        CL_C,
        CL_SPACE,
        CL_WS,
        CL_PLUS,
        CL_MINUS,
        CL_DIGIT,
        CL_OTHER
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [3:0] digit;
        logic       last;
    } t_token;

endpackage

`default_nettype wire

[src/dcp_in_if.sv]
`default_nettype none

interface dcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       chunk_end;

    modport source (output valid, output text_byte, output chunk_end, input ready);
    modport sink   (input valid, input text_byte, input chunk_end, output ready);
endinterface

`default_nettype wire

[src/dcp_out_if.sv]
`default_nettype none

interface dcp_out_if;
    import dcp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DAC_BITS-1:0] first_value;
    logic [DAC_BITS-1:0] second_value;
    logic                range_fault;
    logic                loaded;
    logic [DAC_BITS-1:0] dac_one;
    logic [DAC_BITS-1:0] dac_two;

    modport source (
        output valid, output status, output first_value, output second_value,
        output range_fault, output loaded, output dac_one, output dac_two,
        input ready
    );
    modport sink (
        input valid, input status, input first_value, input second_value,
        input range_fault, input loaded, input dac_one, input dac_two,
        output ready
    );
endinterface

`default_nettype wire

[src/dcp_front.sv]
`default_nettype none

module dcp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dcp_in_if.sink          i_cmd,
    output logic            o_tok_valid,
    output dcp_pkg::t_token o_tok,
    input  logic            i_tok_ready
);
    import dcp_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        case (b) inside
            CH_NUL:        c = CL_NUL;
            CH_D:          c = CL_D;
            CH_A:          c = CL_A;
            CH_C:          c = CL_C;
            CH_SPACE:      c = CL_SPACE;
            [CH_TAB:CH_CR]: c = CL_WS;
            CH_PLUS:       c = CL_PLUS;
            CH_MINUS:      c = CL_MINUS;
            [CH_0:CH_9]:   c = CL_DIGIT;
            default:       c = CL_OTHER;
        endcase
        return c;
    endfunction

    logic   r_valid;
    logic   n_valid;
    t_token r_tok;
    logic   accept;

    assign i_cmd.ready = !r_valid || i_tok_ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign n_valid     = accept ? 1'b1 : (i_tok_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok.cls   <= classify(i_cmd.text_byte);
            // low nibble of an ascii digit is its value
            r_tok.digit <= i_cmd.text_byte[3:0];
            r_tok.last  <= i_cmd.chunk_end;
        end
    end

    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

endmodule

`default_nettype wire

[src/dcp_queue.sv]
`default_nettype none

module dcp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  dcp_pkg::t_token i_push_tok,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output dcp_pkg::t_token o_pop_tok,
    input  logic            i_pop_ready
);
    import dcp_pkg::*;

    t_token            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

endmodule

`default_nettype wire

[src/dcp_back.sv]
`default_nettype none

module dcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  dcp_pkg::t_token i_tok,
    output logic            o_tok_ready,
    dcp_out_if.source       o_res
);
    import dcp_pkg::*;

    // verdict when the command stops in the given phase
    function automatic t_status term_code(input t_phase p);
        t_status s;
        unique case (p)
            PH_D, PH_A, PH_C:            s = ST_NOT_DAC;
            PH_SEP, PH_SKIP1, PH_SIGN1:  s = ST_NO_FIRST;
            PH_DIG1, PH_SKIP2, PH_SIGN2: s = ST_NO_SECOND;
            default:                     s = ST_OK;
        endcase
        return s;
    endfunction

    // parse state
    t_phase    r_phase;
    t_status   r_verdict;
    t_dac_word r_acc1, r_acc2;
    logic      r_over1, r_over2, r_neg1, r_neg2;
    t_dac_word r_held1, r_held2;

    // result register
    logic      r_out_valid;
    t_status   r_status;
    t_dac_word r_val1, r_val2;
    logic      r_fault, r_load;

    logic      take;
    logic      is_space, is_sign, is_digit, is_minus;
    t_phase    p_byte;
    t_status   v_byte, v_final;
    logic      do_add, add_second, set_neg1, set_neg2;

    t_dac_word       acc_sel;
    logic            over_sel;
    logic [ACC_W-1:0] prod;
    logic            sum_over, add_ok;
    t_dac_word       sum_word;
    t_dac_word       n_acc1, n_acc2;
    logic            n_over1, n_over2, n_neg1, n_neg2;
    logic            got1, got2, fault1, fault2, fault, load;
    t_dac_word       val1, val2;
    logic            n_out_valid;

    assign o_tok_ready = !i_tok.last || !r_out_valid || o_res.ready;
    assign take        = i_tok_valid && o_tok_ready;

    assign is_space = (i_tok.cls == CL_SPACE) || (i_tok.cls == CL_WS);
    assign is_sign  = (i_tok.cls == CL_PLUS) || (i_tok.cls == CL_MINUS);
    assign is_digit = i_tok.cls == CL_DIGIT;
    assign is_minus = i_tok.cls == CL_MINUS;

    // phase transition for one byte
    always_comb begin
        p_byte     = r_phase;
        v_byte     = r_verdict;
        do_add     = 1'b0;
        add_second = 1'b0;
        set_neg1   = 1'b0;
        set_neg2   = 1'b0;
        if (r_phase != PH_DONE) begin
            if (i_tok.cls == CL_NUL) begin
                v_byte = term_code(r_phase);
                p_byte = PH_DONE;
            end else begin
                unique case (r_phase)
                    PH_D: begin
                        if (i_tok.cls == CL_D) p_byte = PH_A;
                        else begin v_byte = ST_NOT_DAC; p_byte = PH_DONE; end
                    end
                    PH_A: begin
                        if (i_tok.cls == CL_A) p_byte = PH_C;
                        else begin v_byte = ST_NOT_DAC; p_byte = PH_DONE; end
                    end
                    PH_C: begin
                        if (i_tok.cls == CL_C) p_byte = PH_SEP;
                        else begin v_byte = ST_NOT_DAC; p_byte = PH_DONE; end
                    end
                    PH_SEP: begin
                        if (i_tok.cls == CL_SPACE) p_byte = PH_SKIP1;
                        else begin v_byte = ST_BAD_SEP; p_byte = PH_DONE; end
                    end
                    PH_SKIP1: begin
                        if (is_space) begin
                            p_byte = PH_SKIP1;
                        end else if (is_sign) begin
                            set_neg1 = 1'b1;
                            p_byte   = PH_SIGN1;
                        end else if (is_digit) begin
                            do_add = 1'b1;
                            p_byte = PH_DIG1;
                        end else begin
                            v_byte = ST_NO_FIRST;
                            p_byte = PH_DONE;
                        end
                    end
                    PH_SIGN1: begin
                        if (is_digit) begin
                            do_add = 1'b1;
                            p_byte = PH_DIG1;
                        end else begin
                            v_byte = ST_NO_FIRST;
                            p_byte = PH_DONE;
                        end
                    end
                    PH_DIG1, PH_SKIP2: begin
                        if (is_digit) begin
                            do_add = 1'b1;
                            if (r_phase == PH_SKIP2) begin
                                add_second = 1'b1;
                                p_byte     = PH_DIG2;
                            end
                        end else if (is_space) begin
                            p_byte = PH_SKIP2;
                        end else if (is_sign) begin
                            set_neg2 = 1'b1;
                            p_byte   = PH_SIGN2;
                        end else begin
                            v_byte = ST_NO_SECOND;
                            p_byte = PH_DONE;
                        end
                    end
                    PH_SIGN2: begin
                        if (is_digit) begin
                            do_add     = 1'b1;
                            add_second = 1'b1;
                            p_byte     = PH_DIG2;
                        end else begin
                            v_byte = ST_NO_SECOND;
                            p_byte = PH_DONE;
                        end
                    end
                    PH_DIG2: begin
                        if (is_digit) begin
                            do_add     = 1'b1;
                            add_second = 1'b1;
                        end else begin
                            v_byte = ST_OK;
                            p_byte = PH_DONE;
                        end
                    end
                    default: begin
                        p_byte = PH_DONE;
                    end
                endcase
            end
        end
        // end of chunk terminates a command still in progress
        v_final = (p_byte != PH_DONE) ? term_code(p_byte) : v_byte;
    end

    // shared digit accumulator: acc * 10 + digit, saturating
    always_comb begin
        acc_sel  = add_second ? r_acc2 : r_acc1;
        over_sel = add_second ? r_over2 : r_over1;
        prod     = (ACC_W'(acc_sel) << 3) + (ACC_W'(acc_sel) << 1) + ACC_W'(i_tok.digit);
        sum_over = prod > ACC_W'(VAL_MAX);
        sum_word = sum_over ? VAL_MAX : prod[DAC_BITS-1:0];
        add_ok   = do_add && !over_sel;

        n_acc1  = r_acc1;
        n_acc2  = r_acc2;
        n_over1 = r_over1;
        n_over2 = r_over2;
        if (add_ok && !add_second) begin
            n_acc1  = sum_word;
            n_over1 = r_over1 || sum_over;
        end
        if (add_ok && add_second) begin
            n_acc2  = sum_word;
            n_over2 = r_over2 || sum_over;
        end
        n_neg1 = set_neg1 ? is_minus : r_neg1;
        n_neg2 = set_neg2 ? is_minus : r_neg2;

        got1   = (v_final == ST_OK) || (v_final == ST_NO_SECOND);
        got2   = v_final == ST_OK;
        fault1 = n_over1 || (n_neg1 && (n_acc1 != '0));
        fault2 = n_over2 || (n_neg2 && (n_acc2 != '0));
        val1   = got1 ? (fault1 ? VAL_MAX : n_acc1) : '0;
        val2   = got2 ? (fault2 ? VAL_MAX : n_acc2) : '0;
        fault  = (got1 && fault1) || (got2 && fault2);
        load   = got2 && !fault;
    end

    assign n_out_valid = (take && i_tok.last) ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_D;
            r_verdict   <= ST_OK;
            r_acc1      <= '0;
            r_acc2      <= '0;
            r_over1     <= 1'b0;
            r_over2     <= 1'b0;
            r_neg1      <= 1'b0;
            r_neg2      <= 1'b0;
            r_held1     <= VAL_MID;
            r_held2     <= VAL_MID;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take) begin
                if (i_tok.last) begin
                    r_phase   <= PH_D;
                    r_verdict <= ST_OK;
                    r_acc1    <= '0;
                    r_acc2    <= '0;
                    r_over1   <= 1'b0;
                    r_over2   <= 1'b0;
                    r_neg1    <= 1'b0;
                    r_neg2    <= 1'b0;
                    if (load) begin
                        r_held1 <= val1;
                        r_held2 <= val2;
                    end
                end else begin
                    r_phase   <= p_byte;
                    r_verdict <= v_byte;
                    r_acc1    <= n_acc1;
                    r_acc2    <= n_acc2;
                    r_over1   <= n_over1;
                    r_over2   <= n_over2;
                    r_neg1    <= n_neg1;
                    r_neg2    <= n_neg2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_tok.last) begin
            r_status <= v_final;
            r_val1   <= val1;
            r_val2   <= val2;
            r_fault  <= fault;
            r_load   <= load;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.first_value  = r_val1;
    assign o_res.second_value = r_val2;
    assign o_res.range_fault  = r_fault;
    assign o_res.loaded       = r_load;
    // held words only change on a chunk end, so they match the pending result
    assign o_res.dac_one      = r_held1;
    assign o_res.dac_two      = r_held2;

endmodule

`default_nettype wire

[src/dac_command_parser.sv]
// dac command parser: takes command text one byte per transaction on i_cmd
// and recognizes "DAC <n1> <n2>" with optional signs and whitespace.
// i_cmd carries text_byte and chunk_end; a transaction with chunk_end high
// closes the command and yields exactly one result transaction on o_res,
// other bytes yield none. o_res carries the status (0 ok, 1 not DAC,
// 2 bad separator, 3 no first number, 4 no second number), both parsed
// channels clamped to the top code, the range fault flag, the load flag and
// the two held DAC words as they stand after the command.
// throughput: one byte per cycle outside a stall; the parse step is a
// single multiply-by-ten and add per byte in the back end.
// result path: the last byte goes through the classify register, then the
// queue, then the result register.
// reset: synchronous active low; parsing restarts, both held words go to
// mid scale, queue and result register empty.
// stall: while o_res is held off the result waits in its register; bytes
// keep flowing into the 4-entry queue until a second chunk end reaches the
// back end, then the queue fills and i_cmd.ready drops.
`default_nettype none

module dac_command_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcp_in_if.sink    i_cmd,
    dcp_out_if.source o_res
);
    import dcp_pkg::*;

    // front end to queue
    logic   front_valid;
    t_token front_tok;
    logic   front_ready;

    // queue to back end
    logic   q_valid;
    t_token q_tok;
    logic   q_ready;

    // classify each byte and register it
    dcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_tok_ready (front_ready)
    );

    // short token queue lets the front keep taking bytes during a stall
    dcp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_tok   (front_tok),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_tok    (q_tok),
        .i_pop_ready  (q_ready)
    );

    // parse state machine, number accumulation, held words, result register
    dcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_ready (q_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

[src/dcp_checker.sv]
`default_nettype none

`include "dac_command_parser_defines.svh"

module dcp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [dcp_pkg::STATUS_W-1:0] i_status,
    input logic [dcp_pkg::DAC_BITS-1:0] i_first_value,
    input logic [dcp_pkg::DAC_BITS-1:0] i_second_value,
    input logic                         i_range_fault,
    input logic                         i_loaded,
    input logic [dcp_pkg::DAC_BITS-1:0] i_dac_one,
    input logic [dcp_pkg::DAC_BITS-1:0] i_dac_two
);
    import dcp_pkg::*;

    // stalled result holds its payload
    `DCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_first_value) && $stable(i_second_value), "stalled result changed")

    // a load only on a clean command and the held words take the parsed values
    `DCP_ASSERT_NOW(a_load_clean, i_clk, i_rst_n, i_out_valid && i_loaded, i_status == ST_OK && !i_range_fault && i_dac_one == i_first_value && i_dac_two == i_second_value, "bad load")

    // second channel unparsed unless the command is ok
    `DCP_ASSERT_NOW(a_no_second, i_clk, i_rst_n, i_out_valid && i_status != ST_OK, i_second_value == '0 && !i_loaded, "second channel set on failed command")

    // first channel unparsed before the first number
    `DCP_ASSERT_NOW(a_no_first, i_clk, i_rst_n, i_out_valid && i_status != ST_OK && i_status != ST_NO_SECOND, i_first_value == '0 && !i_range_fault, "first channel set on early failure")

endmodule

bind dac_command_parser dcp_checker u_dcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_first_value  (o_res.first_value),
    .i_second_value (o_res.second_value),
    .i_range_fault  (o_res.range_fault),
    .i_loaded       (o_res.loaded),
    .i_dac_one      (o_res.dac_one),
    .i_dac_two      (o_res.dac_two)
);

`default_nettype wire
